@@ src/mcdc_pkg.sv @@
package mcdc_pkg;

	localparam int unsigned NumW   = 35;
	localparam int unsigned DivW   = 33;
	localparam int unsigned Cells  = NumW;

	localparam logic [24:0] OscHz      = 25'd24000000;
	localparam logic [31:0] OscLimitHz = 32'd4000000;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SRC  = 2'd1,
		ST_DIV_HIGH = 2'd2,
		ST_ZERO     = 2'd3
	} status_t;

	typedef struct packed {
		logic       func;
		logic       zero;
		logic       bad_src;
		logic       src;
		logic [1:0] n;
	} meta_t;

	typedef struct packed {
		logic [DivW-1:0] rem;
		logic [NumW-1:0] nq;
		logic [DivW-1:0] d;
		meta_t           meta;
	} stage_t;

	typedef struct packed {
		logic        func;
		logic [31:0] target_rate;
		logic [31:0] clock_word_in;
	} req_t;

	typedef struct packed {
		logic [31:0] clock_word_out;
		logic [32:0] rate_hz;
		logic [1:0]  status;
	} rsp_t;

endpackage

@@ src/mcdc_if.sv @@
interface mcdc_req_if;
	import mcdc_pkg::*;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] target_rate;
	logic [31:0] clock_word_in;
	modport source (output valid, func, target_rate, clock_word_in, input ready);
	modport sink (input valid, func, target_rate, clock_word_in, output ready);
endinterface

interface mcdc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] clock_word_out;
	logic [32:0] rate_hz;
	logic [1:0]  status;
	modport source (output valid, clock_word_out, rate_hz, status, input ready);
	modport sink (input valid, clock_word_out, rate_hz, status, output ready);
endinterface

@@ src/mcdc_cell.sv @@
module mcdc_cell
	import mcdc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   v_in,
	input  stage_t s_in,
	output logic   v_out,
	output stage_t s_out
);

	logic [DivW:0]   trial;
	logic            ge;
	logic [DivW:0]   diff;
	stage_t          nxt;
	logic            v_q;
	stage_t          s_q;

	// one restoring step: one quotient bit per cell
	always_comb begin
		trial = {s_in.rem, s_in.nq[NumW-1]};
		ge    = trial >= {1'b0, s_in.d};
		diff  = trial - {1'b0, s_in.d};
		nxt       = s_in;
		nxt.rem   = ge ? diff[DivW-1:0] : trial[DivW-1:0];
		nxt.nq    = {s_in.nq[NumW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_q <= nxt;
		end
	end

	assign v_out = v_q;
	assign s_out = s_q;

endmodule

@@ src/mmc_clock_divider_calc_core.sv @@
// channel | dir | handshake     | payload
// req     | in  | valid/ready   | func, target_rate, clock_word_in
// rsp     | out | valid/ready   | clock_word_out, rate_hz, status
// cfg     | in  | cfg_we        | cfg_wdata (PLL control word)
// One request per cycle while rsp is not stalled; pipeline: input stage plus 35 divider cells.
// The 35-cell restoring divider chain sets the latency; one quotient bit per cell.
// Reset clears the PLL word and all valid bits.
// A stalled response freezes the whole chain; req.ready drops only then.
module mmc_clock_divider_calc_core
	import mcdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	mcdc_req_if.sink    req,
	mcdc_rsp_if.source  rsp
);

	logic [31:0] pll_q;
	logic        en;
	logic [8:0]  mul;
	logic [33:0] pll_prod;
	logic [33:0] pll_hz;
	logic [1:0]  psh;
	logic [33:0] src_hz;
	stage_t      prep;
	logic        v_s1;
	stage_t      st_s1;
	logic        v_c [Cells+1];
	stage_t      s_c [Cells+1];
	stage_t      last;
	logic [NumW-1:0] q;
	logic [NumW-1:0] dv;
	logic [NumW-1:0] hz_sh;
	logic [1:0]  n;
	logic [4:0]  m;
	rsp_t        r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pll_q <= '0;
		end else if (cfg_we) begin
			pll_q <= cfg_wdata;
		end
	end

	assign en        = !(rsp.valid && !rsp.ready);
	assign req.ready = en;

	always_comb begin
		mul      = {1'b0, pll_q[15:8]} + 9'd1;
		pll_prod = 34'(OscHz) * 34'(mul);
		psh      = {1'b0, pll_q[0]} + {1'b0, pll_q[1]};
		pll_hz   = pll_prod >> psh;

		prep           = '0;
		prep.meta.func = req.func;
		if (!req.func) begin
			prep.meta.zero = req.target_rate == '0;
			prep.meta.src  = req.target_rate > OscLimitHz;
			src_hz         = prep.meta.src ? pll_hz : 34'(OscHz);
			prep.nq        = {src_hz, 1'b0} + NumW'(req.target_rate);
			prep.d         = {req.target_rate, 1'b0};
		end else begin
			prep.meta.bad_src = req.clock_word_in[25];
			prep.meta.src     = req.clock_word_in[24];
			prep.meta.n       = req.clock_word_in[9:8];
			src_hz            = req.clock_word_in[24] ? pll_hz : 34'(OscHz);
			prep.nq           = {1'b0, src_hz};
			prep.d            = DivW'({1'b0, req.clock_word_in[3:0]} + 5'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= prep;
		end
	end

	assign v_c[0] = v_s1;
	assign s_c[0] = st_s1;

	for (genvar i = 0; i < Cells; i++) begin : g_cell
		mcdc_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_in  (v_c[i]),
			.s_in  (s_c[i]),
			.v_out (v_c[i+1]),
			.s_out (s_c[i+1])
		);
	end

	always_comb begin
		last  = s_c[Cells];
		q     = last.nq;
		dv    = (q == '0) ? NumW'(1) : q;
		hz_sh = q >> last.meta.n;
		r     = '0;
		n     = 2'd0;
		m     = 5'd1;
		if (!last.meta.func) begin
			if (last.meta.zero) begin
				r.status = ST_ZERO;
			end else begin
				if (dv > NumW'(128)) begin
					r.status = ST_DIV_HIGH;
				end else if (dv > NumW'(64)) begin
					n = 2'd3;
					m = dv[7:3];
				end else if (dv > NumW'(32)) begin
					n = 2'd2;
					m = dv[6:2];
				end else if (dv > NumW'(16)) begin
					n = 2'd1;
					m = dv[5:1];
				end else begin
					m = dv[4:0];
				end
				r.clock_word_out = {7'd0, last.meta.src, 14'd0, n, 4'd0,
					4'(m - 5'd1)};
			end
		end else if (last.meta.bad_src) begin
			r.status = ST_BAD_SRC;
		end else begin
			r.rate_hz = hz_sh[32:0];
		end
	end

	assign rsp.valid          = v_c[Cells];
	assign rsp.clock_word_out = r.clock_word_out;
	assign rsp.rate_hz        = r.rate_hz;
	assign rsp.status         = r.status;

endmodule

@@ src/mcdc_chk.sv @@
module mcdc_chk
	import mcdc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_cw,
	input logic [32:0] out_hz,
	input logic [1:0]  out_st
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response dropped while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("request stalled without response stall");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_st == ST_ZERO |-> out_cw == '0 && out_hz == '0)
		else $error("zero rate response not empty");

	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_st == ST_BAD_SRC |-> out_hz == '0 && out_cw == '0)
		else $error("bad source gave a rate");

	a_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_st == ST_DIV_HIGH |-> out_cw[23:0] == '0 && out_hz == '0)
		else $error("high divisor word not cleared");

endmodule

bind mmc_clock_divider_calc_core mcdc_chk u_mcdc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.out_cw   (rsp.clock_word_out),
	.out_hz   (rsp.rate_hz),
	.out_st   (rsp.status)
);
